// ===== rtl/gsh_pkg.sv =====
// ----------------------------------------------------------------------------
// gsh_pkg
// Shared types and constants for the gamepad serial host.
// ----------------------------------------------------------------------------
package gsh_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_WAIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_HIGH = 3'd6;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_INIT = 2'd1;
    localparam logic [1:0] CMD_POLL = 2'd2;

    localparam logic [7:0] MODE_ANALOG = 8'h73;

    typedef struct packed {
        logic [1:0] cmd;
        logic       data_in;
        logic       ack_in;
    } t_in_word;

    typedef struct packed {
        logic       clock_out;
        logic       command_out;
        logic       attention_out;
        logic       busy_res;
        logic       done_res;
        logic       status;
        logic [4:0] button;
        logic [7:0] mode_id;
        logic [7:0] buttons_first;
        logic [7:0] buttons_second;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  half_bit_ticks;
        logic [19:0] frame_gap_ticks;
        logic [19:0] retry_gap_ticks;
        logic [7:0]  max_attempts;
        logic [7:0]  ack_wait_ticks;
        logic [7:0]  axis_low_limit;
        logic [7:0]  axis_high_limit;
    } t_cfg;

    function automatic logic [7:0] frame_cmd(input logic [1:0] f, input logic [3:0] b);
        logic [7:0] v;
        v = 8'h00;
        case (b)
            4'd0: v = 8'h01;
            4'd1: begin
                case (f)
                    2'd0: v = 8'h43;
                    2'd1: v = 8'h44;
                    2'd2: v = 8'h43;
                    default: v = 8'h42;
                endcase
            end
            4'd3: v = (f == 2'd0 || f == 2'd1) ? 8'h01 : 8'h00;
            4'd4: begin
                case (f)
                    2'd1: v = 8'h03;
                    2'd2: v = 8'h5A;
                    default: v = 8'h00;
                endcase
            end
            4'd5, 4'd6, 4'd7, 4'd8: v = (f == 2'd2) ? 8'h5A : 8'h00;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/gsh_stream_if.sv =====
// ----------------------------------------------------------------------------
// gsh_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface gsh_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gsh_decode.sv =====
// ----------------------------------------------------------------------------
// gsh_decode
// Turns a poll reply into a dense button code.
// ----------------------------------------------------------------------------
module gsh_decode (
    input  logic [7:0] i_reply [8],
    input  logic [7:0] i_axis_low,
    input  logic [7:0] i_axis_high,
    output logic [4:0] o_button
);
    logic [7:0] v;
    always_comb begin
        o_button = 5'd0;
        v = 8'd128;
        if (i_reply[1] == 8'd255) begin
            o_button = 5'd0;
        end else if (i_reply[2] != 8'd255) begin
            case (i_reply[2])
                8'd127: o_button = 5'd1;
                8'd191: o_button = 5'd2;
                8'd223: o_button = 5'd3;
                8'd239: o_button = 5'd4;
                8'd254: o_button = 5'd5;
                8'd247: o_button = 5'd6;
                default: o_button = 5'd0;
            endcase
        end else if (i_reply[3] != 8'd255) begin
            case (i_reply[3])
                8'd223: o_button = 5'd7;
                8'd191: o_button = 5'd8;
                8'd127: o_button = 5'd9;
                8'd239: o_button = 5'd10;
                8'd251: o_button = 5'd11;
                8'd254: o_button = 5'd12;
                8'd247: o_button = 5'd13;
                8'd253: o_button = 5'd14;
                default: o_button = 5'd0;
            endcase
        end else begin
            for (int k = 7; k >= 4; k--) begin
                if (i_reply[k] != 8'd128) begin
                    v = i_reply[k];
                    if (v <= i_axis_low)       o_button = 5'(15 + 2 * (k - 4));
                    else if (v >= i_axis_high) o_button = 5'(16 + 2 * (k - 4));
                    else                       o_button = 5'd0;
                end
            end
        end
    end
endmodule

// ===== rtl/gamepad_serial_host_top.sv =====
// ----------------------------------------------------------------------------
// gamepad_serial_host_top
// Tick-stepped host for a game-controller serial link: init and poll.
// ----------------------------------------------------------------------------
// Each input word is one tick; one word is taken per cycle while the skid is
// empty. Its result word is built combinationally from the input word and the
// frame sequencer's state and is registered in the output register, or first
// in a one-word skid when the output side stalls, which drops input ready.
module gamepad_serial_host_top #(
    parameter int FRAME_BYTES = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gsh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gsh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    gsh_stream_if.sink                      in_ch,
    gsh_stream_if.source                    out_ch
);
    import gsh_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SELECT, PH_LOW, PH_HIGH, PH_ACK, PH_GAP
    } t_phase;

    localparam logic [3:0] LAST_BYTE = 4'(FRAME_BYTES - 1);

    t_cfg       r_cfg;
    t_phase     r_phase, n_phase;
    logic [1:0] r_frame, n_frame;
    logic [3:0] r_byte, n_byte;
    logic [2:0] r_bit, n_bit;
    logic [19:0] r_tick, n_tick;
    logic [7:0] r_att, n_att;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_reply [8];
    logic [7:0] n_reply [8];
    logic [4:0] r_button, n_button;
    logic       r_status, n_status;
    logic       r_init, n_init;
    logic       n_done;
    logic [4:0] dec_button;
    logic [7:0] cbyte;
    logic       cmo;
    logic       fire;
    t_out_word  n_word, r_out, r_skid;
    logic       r_out_v, r_skid_v;
    logic       tick_end;
    logic [19:0] gap_lim;

    gsh_decode u_decode (
        .i_reply    (r_reply),
        .i_axis_low (r_cfg.axis_low_limit),
        .i_axis_high(r_cfg.axis_high_limit),
        .o_button   (dec_button)
    );

    assign in_ch.ready = !r_skid_v;
    assign fire = in_ch.valid && in_ch.ready;
    assign tick_end = (r_tick + 20'd1) >= {12'd0, r_cfg.half_bit_ticks};
    assign gap_lim = (r_frame == 2'd3) ? r_cfg.retry_gap_ticks : r_cfg.frame_gap_ticks;

    always_comb begin
        n_phase = r_phase; n_frame = r_frame; n_byte = r_byte; n_bit = r_bit;
        n_tick = r_tick; n_att = r_att; n_shift = r_shift; n_reply = r_reply;
        n_button = r_button; n_status = r_status; n_init = r_init; n_done = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (in_ch.data.cmd == CMD_INIT || in_ch.data.cmd == CMD_POLL) begin
                    n_init = (in_ch.data.cmd == CMD_INIT);
                    if (in_ch.data.cmd == CMD_INIT) n_att = 8'd0;
                    n_frame = (in_ch.data.cmd == CMD_INIT) ? 2'd0 : 2'd3;
                    n_byte = 4'd0; n_bit = 3'd0; n_tick = 20'd0; n_shift = 8'd0;
                    if (in_ch.data.cmd == CMD_POLL)
                        for (int i = 0; i < 8; i++) n_reply[i] = (i < 4) ? 8'd255 : 8'd128;
                    n_phase = PH_SELECT;
                end
            end
            PH_SELECT: begin
                if (tick_end) begin n_tick = 20'd0; n_phase = PH_LOW; end
                else n_tick = r_tick + 20'd1;
            end
            PH_LOW: begin
                if (tick_end) begin
                    n_shift = r_shift | (8'(in_ch.data.data_in) << r_bit);
                    n_tick = 20'd0; n_phase = PH_HIGH;
                end else n_tick = r_tick + 20'd1;
            end
            PH_HIGH: begin
                if (tick_end) begin
                    n_tick = 20'd0;
                    if (r_bit == 3'd7) begin
                        if (r_frame == 2'd3 && r_byte >= 4'd1 && r_byte <= 4'd8)
                            n_reply[3'(r_byte - 4'd1)] = r_shift;
                        n_bit = 3'd0; n_phase = PH_ACK;
                    end else begin
                        n_bit = r_bit + 3'd1; n_phase = PH_LOW;
                    end
                end else n_tick = r_tick + 20'd1;
            end
            PH_ACK: begin
                if (!in_ch.data.ack_in ||
                    (r_tick + 20'd1) >= {12'd0, r_cfg.ack_wait_ticks}) begin
                    n_tick = 20'd0;
                    if (r_byte >= ((r_frame == 2'd0) ? 4'd4 : LAST_BYTE)) begin
                        if (r_init) n_phase = PH_GAP;
                        else begin
                            n_button = dec_button; n_status = 1'b0;
                            n_phase = PH_IDLE; n_done = 1'b1;
                        end
                    end else begin
                        n_byte = r_byte + 4'd1; n_shift = 8'd0; n_phase = PH_LOW;
                    end
                end else n_tick = r_tick + 20'd1;
            end
            PH_GAP: begin
                if ((r_tick + 20'd1) >= gap_lim) begin
                    n_tick = 20'd0;
                    n_byte = 4'd0; n_bit = 3'd0; n_shift = 8'd0;
                    if (r_frame != 2'd3) begin
                        n_frame = r_frame + 2'd1;
                        if (r_frame == 2'd2)
                            for (int i = 0; i < 8; i++)
                                n_reply[i] = (i < 4) ? 8'd255 : 8'd128;
                        n_phase = PH_SELECT;
                    end else if (r_reply[0] == MODE_ANALOG) begin
                        n_status = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                    end else begin
                        n_att = r_att + 8'd1;
                        if (n_att >= r_cfg.max_attempts || n_att == 8'd0) begin
                            n_status = 1'b1; n_phase = PH_IDLE; n_done = 1'b1;
                        end else begin
                            n_frame = 2'd0; n_phase = PH_SELECT;
                        end
                    end
                end else n_tick = r_tick + 20'd1;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    assign cbyte = frame_cmd(n_frame, n_byte);
    assign cmo = cbyte[n_bit];

    always_comb begin
        n_word = '0;
        n_word.clock_out     = (n_phase != PH_LOW);
        n_word.command_out   = (n_phase == PH_LOW || n_phase == PH_HIGH) ? cmo : 1'b1;
        n_word.attention_out = !(n_phase == PH_SELECT || n_phase == PH_LOW ||
                                 n_phase == PH_HIGH || n_phase == PH_ACK);
        n_word.busy_res      = (n_phase != PH_IDLE);
        n_word.done_res      = n_done;
        n_word.status        = n_status;
        n_word.button        = n_button;
        n_word.mode_id       = n_reply[0];
        n_word.buttons_first = n_reply[2];
        n_word.buttons_second = n_reply[3];
    end

    assign out_ch.valid = r_out_v;
    assign out_ch.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{8'd8, 20'd1000, 20'd100000, 8'd255, 8'd20, 8'd117, 8'd138};
            r_phase <= PH_IDLE; r_frame <= 2'd0; r_byte <= 4'd0; r_bit <= 3'd0;
            r_tick <= 20'd0; r_att <= 8'd0; r_shift <= 8'd0;
            for (int i = 0; i < 8; i++) r_reply[i] <= (i < 4) ? 8'd255 : 8'd128;
            r_button <= 5'd0; r_status <= 1'b0; r_init <= 1'b0;
            r_out_v <= 1'b0; r_skid_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HALF_BIT:  r_cfg.half_bit_ticks  <= i_cfg_data[7:0];
                    REG_FRAME_GAP: r_cfg.frame_gap_ticks <= i_cfg_data;
                    REG_RETRY_GAP: r_cfg.retry_gap_ticks <= i_cfg_data;
                    REG_MAX_ATT:   r_cfg.max_attempts    <= i_cfg_data[7:0];
                    REG_ACK_WAIT:  r_cfg.ack_wait_ticks  <= i_cfg_data[7:0];
                    REG_AXIS_LOW:  r_cfg.axis_low_limit  <= i_cfg_data[7:0];
                    REG_AXIS_HIGH: r_cfg.axis_high_limit <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (fire) begin
                r_phase <= n_phase; r_frame <= n_frame; r_byte <= n_byte;
                r_bit <= n_bit; r_tick <= n_tick; r_att <= n_att;
                r_shift <= n_shift; r_reply <= n_reply; r_button <= n_button;
                r_status <= n_status; r_init <= n_init;
            end
            // output register with one-word skid
            if (!r_out_v || out_ch.ready) begin
                if (r_skid_v) begin
                    r_out <= r_skid; r_out_v <= 1'b1; r_skid_v <= 1'b0;
                end else begin
                    r_out <= n_word; r_out_v <= fire;
                end
            end else if (fire) begin
                r_skid <= n_word; r_skid_v <= 1'b1;
            end
        end
    end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gamepad serial host. A behavioral controller
// answers the frames, a cycle model predicts every result word, and each
// output word is compared field by field while both channel sides stall.
// ----------------------------------------------------------------------------
module tb_top;
    import gsh_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_SELECT, PH_LOW, PH_HIGH, PH_ACK, PH_GAP
    } t_phase;

    localparam int CYCLE_LIMIT = 100000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gsh_stream_if #(.T(t_in_word)) in_ch ();
    gsh_stream_if #(.T(t_out_word)) out_ch ();

    gamepad_serial_host_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    // command bytes per frame: enter config, set analog, exit config, poll
    localparam logic [7:0] CMD_TBL [4][9] = '{
        '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A},
        '{8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [7:0] DPAD_CODE [6] = '{8'd127, 8'd191, 8'd223, 8'd239, 8'd254, 8'd247};
    localparam logic [7:0] FACE_CODE [8] = '{8'd223, 8'd191, 8'd127, 8'd239,
                                             8'd251, 8'd254, 8'd247, 8'd253};

    // predicted sequencer state and registers
    t_cfg        cfg;
    t_phase      phase;
    logic [1:0]  frame_sel;
    logic [3:0]  byte_pos;
    logic [2:0]  bit_pos;
    logic [19:0] ticks;
    logic [7:0]  attempts;
    logic [7:0]  rx_shift;
    logic [7:0]  replies [8];
    logic [4:0]  last_button;
    logic        last_status;
    logic        init_run;
    logic        op_done;

    t_out_word   expected_words[$];
    int          send_idle_pct, recv_idle_pct;
    int          hold_req_len, hold_req_id;
    int          hold_seen, hold_left;
    int          n_words, n_checked, n_errors, n_polls, n_inits, n_fails;
    int          cycles = 0;

    // controller reply for the current frame
    logic [7:0]  pad_reply [9];
    bit          pad_fixed;
    int          mode_ok_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void idle_replies();
        for (int i = 0; i < 8; i++) replies[i] = (i < 4) ? 8'd255 : 8'd128;
    endfunction

    function automatic void open_frame(input logic [1:0] f);
        frame_sel = f;
        byte_pos = 0; bit_pos = 0; ticks = 0; rx_shift = 0;
        if (f == 2'd3) idle_replies();
        phase = PH_SELECT;
    endfunction

    function automatic logic [4:0] decode_button();
        int v;
        if (replies[1] == 8'd255) return 5'd0;
        if (replies[2] != 8'd255) begin
            for (int k = 0; k < 6; k++) if (replies[2] == DPAD_CODE[k]) return 5'(k + 1);
            return 5'd0;
        end
        if (replies[3] != 8'd255) begin
            for (int k = 0; k < 8; k++) if (replies[3] == FACE_CODE[k]) return 5'(k + 7);
            return 5'd0;
        end
        for (int k = 4; k < 8; k++) begin
            v = replies[k];
            if (v != 128) begin
                if (v <= cfg.axis_low_limit) return 5'(15 + 2 * (k - 4));
                if (v >= cfg.axis_high_limit) return 5'(16 + 2 * (k - 4));
                return 5'd0;
            end
        end
        return 5'd0;
    endfunction

    function automatic logic cmd_line_bit();
        logic [7:0] b;
        b = (byte_pos < 9) ? CMD_TBL[frame_sel][byte_pos] : 8'h00;
        return b[bit_pos];
    endfunction

    function automatic t_out_word predict_tick(input t_in_word w);
        t_out_word o;
        int        flen;
        int        gap;
        op_done = 1'b0;
        case (phase)
            PH_IDLE: begin
                if (w.cmd == CMD_INIT) begin
                    init_run = 1'b1; attempts = 0; open_frame(2'd0);
                end else if (w.cmd == CMD_POLL) begin
                    init_run = 1'b0; open_frame(2'd3);
                end
            end
            PH_SELECT: begin
                if (ticks + 1 >= cfg.half_bit_ticks) begin
                    ticks = 0; phase = PH_LOW;
                end else ticks++;
            end
            PH_LOW: begin
                if (ticks + 1 >= cfg.half_bit_ticks) begin
                    rx_shift[bit_pos] = rx_shift[bit_pos] | w.data_in;
                    ticks = 0; phase = PH_HIGH;
                end else ticks++;
            end
            PH_HIGH: begin
                if (ticks + 1 >= cfg.half_bit_ticks) begin
                    ticks = 0;
                    if (bit_pos == 3'd7) begin
                        if (frame_sel == 2'd3 && byte_pos >= 1 && byte_pos <= 8)
                            replies[3'(byte_pos - 1)] = rx_shift;
                        bit_pos = 0; phase = PH_ACK;
                    end else begin
                        bit_pos++; phase = PH_LOW;
                    end
                end else ticks++;
            end
            PH_ACK: begin
                if (!w.ack_in || ticks + 1 >= cfg.ack_wait_ticks) begin
                    ticks = 0;
                    flen = (frame_sel == 2'd0) ? 5 : 9;
                    if (byte_pos + 1 >= flen) begin
                        if (init_run) phase = PH_GAP;
                        else begin
                            last_button = decode_button();
                            last_status = 1'b0; phase = PH_IDLE; op_done = 1'b1;
                        end
                    end else begin
                        byte_pos++; rx_shift = 0; phase = PH_LOW;
                    end
                end else ticks++;
            end
            PH_GAP: begin
                gap = (frame_sel == 2'd3) ? cfg.retry_gap_ticks : cfg.frame_gap_ticks;
                if (ticks + 1 >= gap) begin
                    ticks = 0;
                    if (frame_sel < 2'd3) open_frame(frame_sel + 2'd1);
                    else if (replies[0] == MODE_ANALOG) begin
                        last_status = 1'b0; phase = PH_IDLE; op_done = 1'b1;
                    end else begin
                        attempts = attempts + 8'd1;
                        if (attempts >= cfg.max_attempts || attempts == 0) begin
                            last_status = 1'b1; phase = PH_IDLE; op_done = 1'b1;
                        end else open_frame(2'd0);
                    end
                end else ticks++;
            end
            default: phase = PH_IDLE;
        endcase
        o = '0;
        o.clock_out = 1'b1; o.command_out = 1'b1; o.attention_out = 1'b1;
        case (phase)
            PH_SELECT: o.attention_out = 1'b0;
            PH_LOW: begin
                o.clock_out = 1'b0; o.command_out = cmd_line_bit(); o.attention_out = 1'b0;
            end
            PH_HIGH: begin
                o.command_out = cmd_line_bit(); o.attention_out = 1'b0;
            end
            PH_ACK: o.attention_out = 1'b0;
            default: ;
        endcase
        o.busy_res = (phase != PH_IDLE);
        o.done_res = op_done;
        o.status = last_status;
        o.button = last_button;
        o.mode_id = replies[0];
        o.buttons_first = replies[2];
        o.buttons_second = replies[3];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // controller side: reply bytes and input word generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_button_byte(input bit dpad);
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'd255;
            4, 5, 6, 7: return dpad ? DPAD_CODE[$urandom_range(5)] : FACE_CODE[$urandom_range(7)];
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_axis_byte();
        case ($urandom_range(5))
            0, 1, 2: return 8'd128;
            3: return 8'(int'(cfg.axis_low_limit) + $urandom_range(2) - 1);
            4: return 8'(int'(cfg.axis_high_limit) + $urandom_range(2) - 1);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void pick_reply();
        pad_reply[0] = 8'hFF;
        pad_reply[1] = ($urandom_range(99) < mode_ok_pct) ? MODE_ANALOG
                       : ($urandom_range(1) ? 8'h41 : 8'($urandom));
        pad_reply[2] = ($urandom_range(5) == 0) ? 8'd255 : 8'h5A;
        pad_reply[3] = pick_button_byte(1);
        pad_reply[4] = pick_button_byte(0);
        for (int k = 5; k < 9; k++) pad_reply[k] = pick_axis_byte();
    endfunction

    function automatic t_in_word make_word(input logic [1:0] c);
        t_in_word w;
        w.cmd = c;
        w.data_in = 1'($urandom);
        w.ack_in = 1'($urandom);
        if (phase == PH_SELECT && !pad_fixed) pick_reply();
        if (phase == PH_LOW && byte_pos < 9) begin
            w.data_in = pad_reply[byte_pos][bit_pos];
            if (!pad_fixed && $urandom_range(99) < 2) w.data_in = ~w.data_in;
        end
        if (phase == PH_ACK) w.ack_in = ($urandom_range(99) < 40) ? 1'b0 : 1'b1;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers and result checker
    // ------------------------------------------------------------------
    task automatic send_word(input t_in_word w);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(3, 1);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_words.push_back(predict_tick(w));
        n_words++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_HALF_BIT:  cfg.half_bit_ticks = 8'(val);
            REG_FRAME_GAP: cfg.frame_gap_ticks = 20'(val);
            REG_RETRY_GAP: cfg.retry_gap_ticks = 20'(val);
            REG_MAX_ATT:   cfg.max_attempts = 8'(val);
            REG_ACK_WAIT:  cfg.ack_wait_ticks = 8'(val);
            REG_AXIS_LOW:  cfg.axis_low_limit = 8'(val);
            REG_AXIS_HIGH: cfg.axis_high_limit = 8'(val);
            default: ;
        endcase
    endtask

    task automatic run_op(input logic [1:0] c);
        logic [1:0] noise;
        if (c == CMD_POLL) n_polls++;
        if (c == CMD_INIT) n_inits++;
        send_word(make_word(c));
        while (phase != PH_IDLE) begin
            noise = ($urandom_range(9) == 0) ? 2'($urandom) : CMD_TICK;
            send_word(make_word(noise));
        end
        if (c == CMD_INIT && last_status) n_fails++;
    endtask

    task automatic poll_with(input logic [7:0] mode, input logic [7:0] hdr,
                             input logic [7:0] b1, input logic [7:0] b2,
                             input logic [7:0] ax);
        pad_fixed = 1;
        pad_reply[0] = 8'hFF; pad_reply[1] = mode; pad_reply[2] = hdr;
        pad_reply[3] = b1; pad_reply[4] = b2;
        for (int k = 5; k < 9; k++) pad_reply[k] = 8'd128;
        pad_reply[5 + $urandom_range(3)] = ax;
        run_op(CMD_POLL);
        pad_fixed = 0;
    endtask

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word e, a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            if (expected_words.size() == 0) begin
                $error("unexpected result word");
                n_errors++;
            end else begin
                e = expected_words.pop_front();
                check_field("clock_out", 8'(e.clock_out), 8'(a.clock_out));
                check_field("command_out", 8'(e.command_out), 8'(a.command_out));
                check_field("attention_out", 8'(e.attention_out), 8'(a.attention_out));
                check_field("busy_res", 8'(e.busy_res), 8'(a.busy_res));
                check_field("done_res", 8'(e.done_res), 8'(a.done_res));
                check_field("status", 8'(e.status), 8'(a.status));
                check_field("button", 8'(e.button), 8'(a.button));
                check_field("mode_id", e.mode_id, a.mode_id);
                check_field("buttons_first", e.buttons_first, a.buttons_first);
                check_field("buttons_second", e.buttons_second, a.buttons_second);
                n_checked++;
            end
        end
    end

    // result side ready, with a long hold-off counted here on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_seen != hold_req_id) begin
            hold_seen <= hold_req_id;
            hold_left <= hold_req_len;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_plain_ticks();
        t_in_word w;
        for (int i = 0; i < 8; i++) begin
            w.cmd = (i % 2) ? CMD_UNUSED : CMD_TICK;
            w.data_in = i[1];
            w.ack_in = i[2];
            send_word(w);
        end
    endtask

    task automatic test_poll_decode();
        drain();
        write_reg(REG_HALF_BIT, 1);
        write_reg(REG_ACK_WAIT, 3);
        poll_with(8'h73, 8'h5A, DPAD_CODE[3], 8'd255, 8'd128);
        poll_with(8'h41, 8'd255, 8'd0, 8'd0, 8'd0);
        poll_with(8'h73, 8'h5A, 8'd255, FACE_CODE[6], 8'd128);
        poll_with(8'h73, 8'h5A, 8'd255, 8'd252, 8'd128);
        poll_with(8'h73, 8'h5A, 8'd255, 8'd255, 8'd117);
    endtask

    task automatic test_register_limits();
        drain();
        write_reg(REG_HALF_BIT, 255);
        write_reg(REG_FRAME_GAP, 1048575);
        write_reg(REG_RETRY_GAP, 1048575);
        write_reg(REG_AXIS_LOW, 0);
        write_reg(REG_AXIS_HIGH, 255);
        test_plain_ticks();
    endtask

    task automatic test_init();
        drain();
        write_reg(REG_HALF_BIT, 0);
        write_reg(REG_ACK_WAIT, 0);
        write_reg(REG_FRAME_GAP, 0);
        write_reg(REG_RETRY_GAP, 0);
        write_reg(REG_MAX_ATT, 0);
        mode_ok_pct = 0;
        run_op(CMD_INIT);
        drain();
        write_reg(REG_HALF_BIT, 1);
        write_reg(REG_ACK_WAIT, 4);
        write_reg(REG_FRAME_GAP, 2);
        write_reg(REG_RETRY_GAP, 3);
        write_reg(REG_MAX_ATT, 2);
        mode_ok_pct = 50;
        run_op(CMD_INIT);
    endtask

    task automatic random_config();
        drain();
        write_reg(REG_HALF_BIT, $urandom_range(2));
        write_reg(REG_FRAME_GAP, $urandom_range(30));
        write_reg(REG_RETRY_GAP, $urandom_range(30));
        write_reg(REG_MAX_ATT, $urandom_range(4));
        write_reg(REG_ACK_WAIT, $urandom_range(6));
        write_reg(REG_AXIS_LOW, $urandom_range(127));
        write_reg(REG_AXIS_HIGH, $urandom_range(255, 128));
        mode_ok_pct = $urandom_range(80, 20);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        hold_req_len = 300;
        hold_req_id = hold_req_id + 1;
        repeat (2) run_op(CMD_POLL);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        hold_req_len = 0;
        hold_req_id = 0;
        n_words = 0; n_checked = 0; n_errors = 0;
        n_polls = 0; n_inits = 0; n_fails = 0;
        send_idle_pct = 24; recv_idle_pct = 54;
        pad_fixed = 0; mode_ok_pct = 50;
        cfg.half_bit_ticks = 8; cfg.frame_gap_ticks = 1000; cfg.retry_gap_ticks = 100000;
        cfg.max_attempts = 255; cfg.ack_wait_ticks = 20;
        cfg.axis_low_limit = 117; cfg.axis_high_limit = 138;
        phase = PH_IDLE; frame_sel = 0; byte_pos = 0; bit_pos = 0; ticks = 0;
        attempts = 0; rx_shift = 0; idle_replies();
        last_button = 0; last_status = 0; init_run = 0; op_done = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_ticks();
        test_poll_decode();
        test_register_limits();
        send_idle_pct = 54; recv_idle_pct = 24;
        test_init();
        test_backpressure();

        drain();
        repeat (20) @(posedge i_clk);
        $display("%0d words sent, %0d checked: %0d polls, %0d inits (%0d gave up)",
                 n_words, n_checked, n_polls, n_inits, n_fails);
        $display("covered button decode, register limits, zero counts, retries, long stall");
        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
